// ===== hdl/nsng_pkg.sv =====
// Package for the nth smooth number generator: widths, microcode control word,
// sequencer step codes and the microcode program table.
// No dependencies.
`timescale 1ns / 1ps

package nsng_pkg;

    localparam int NSNG_MAX_INDEX = 1024;
    localparam int INDEX_W        = 11;
    localparam int VALUE_W        = 31;
    localparam int PROD_W         = VALUE_W + 3;   // room for x5
    localparam int STEP_W         = 4;

    // Step codes of the microprogram
    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LOOP  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_RD3   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_RD5   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LD5   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_GEN   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_FIN   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_ERR   = 4'd9;

    // Read address source
    typedef enum logic [1:0] {
        RD_P2   = 2'd0,
        RD_P3   = 2'd1,
        RD_P5   = 2'd2,
        RD_LAST = 2'd3
    } rd_src_t;

    // Which cached operand takes the read data
    typedef enum logic [1:0] {
        LD_NONE = 2'd0,
        LD_V2   = 2'd1,
        LD_V3   = 2'd2,
        LD_V5   = 2'd3
    } ld_t;

    // Jump condition
    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_START = 3'd2,
        C_BAD      = 3'd3,
        C_FULL     = 3'd4
    } cond_t;

    typedef struct packed {
        logic              accept;
        rd_src_t           rd_src;
        ld_t               ld;
        logic              gen;
        logic              emit_val;
        logic              emit_err;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic bad;
        logic full;
    } status_t;

    localparam ctrl_t CTRL_NOP = '{
        accept:   1'b0,
        rd_src:   RD_P2,
        ld:       LD_NONE,
        gen:      1'b0,
        emit_val: 1'b0,
        emit_err: 1'b0,
        cond:     C_NEXT,
        target:   STEP_IDLE
    };

    // Microprogram: one control word per step
    function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = CTRL_NOP;
        unique case (step)
            STEP_IDLE:
            begin
                w.accept = 1'b1;
                w.cond   = C_NO_START;
                w.target = STEP_IDLE;
            end
            STEP_CHECK:
            begin
                w.cond   = C_BAD;
                w.target = STEP_ERR;
            end
            STEP_LOOP:
            begin
                w.rd_src = RD_P2;
                w.cond   = C_FULL;
                w.target = STEP_FIN;
            end
            STEP_RD3:
            begin
                w.rd_src = RD_P3;
                w.ld     = LD_V2;
            end
            STEP_RD5:
            begin
                w.rd_src = RD_P5;
                w.ld     = LD_V3;
            end
            STEP_LD5:
            begin
                w.ld = LD_V5;
            end
            STEP_GEN:
            begin
                w.gen    = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = STEP_LOOP;
            end
            STEP_FIN:
            begin
                w.rd_src = RD_LAST;
            end
            STEP_EMIT:
            begin
                w.emit_val = 1'b1;
                w.cond     = C_ALWAYS;
                w.target   = STEP_IDLE;
            end
            STEP_ERR:
            begin
                w.emit_err = 1'b1;
                w.cond     = C_ALWAYS;
                w.target   = STEP_IDLE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/nsng_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nsng_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/nsng_sequencer.sv =====
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on nsng_pkg.
`timescale 1ns / 1ps

module nsng_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  nsng_pkg::status_t stat,
    output nsng_pkg::ctrl_t  ctrl,
    output logic             busy
);
    import nsng_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              take_jump;

    // Current control word
    assign ctrl = ucode_rom(step_reg);
    assign busy = (step_reg != STEP_IDLE);

    // Jump condition decode
    always_comb
    begin
        unique case (ctrl.cond)
            C_NEXT:     take_jump = 1'b0;
            C_ALWAYS:   take_jump = 1'b1;
            C_NO_START: take_jump = !start;
            C_BAD:      take_jump = stat.bad;
            C_FULL:     take_jump = stat.full;
            default:    take_jump = 1'b1;
        endcase
        step_next = take_jump ? ctrl.target : step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== hdl/nsng_datapath.sv =====
// Datapath: sequence store, three pointers, cached operands, min-of-three and
// produced count. Depends on nsng_pkg and nsng_ram.
`timescale 1ns / 1ps

module nsng_datapath #(
    parameter int MAX_INDEX = nsng_pkg::NSNG_MAX_INDEX
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nsng_pkg::INDEX_W-1:0]  index,
    input  nsng_pkg::ctrl_t               ctrl,
    output nsng_pkg::status_t             stat,
    output logic [nsng_pkg::VALUE_W-1:0]  rd_value
);
    import nsng_pkg::*;

    localparam int ADDR_W = (MAX_INDEX > 1) ? $clog2(MAX_INDEX) : 1;

    logic [INDEX_W-1:0] n_reg;
    logic [INDEX_W-1:0] count_reg;
    logic [ADDR_W-1:0]  p2_reg;
    logic [ADDR_W-1:0]  p3_reg;
    logic [ADDR_W-1:0]  p5_reg;
    logic [VALUE_W-1:0] v2_reg;
    logic [VALUE_W-1:0] v3_reg;
    logic [VALUE_W-1:0] v5_reg;

    logic               init;
    logic [INDEX_W-1:0] last_idx;
    logic [PROD_W-1:0]  c2;
    logic [PROD_W-1:0]  c3;
    logic [PROD_W-1:0]  c5;
    logic [PROD_W-1:0]  c23;
    logic [PROD_W-1:0]  cmin;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;

    assign init = ctrl.accept && start;

    // Status back to the sequencer
    assign stat.bad  = (n_reg == '0) || (n_reg > INDEX_W'(MAX_INDEX));
    assign stat.full = (count_reg >= n_reg);

    // Candidates x2, x3, x5 and their minimum
    always_comb
    begin
        c2   = {2'b00, v2_reg, 1'b0};
        c3   = {3'b000, v3_reg} + {2'b00, v3_reg, 1'b0};
        c5   = {3'b000, v5_reg} + {1'b0, v5_reg, 2'b00};
        c23  = (c2 < c3) ? c2 : c3;
        cmin = (c23 < c5) ? c23 : c5;
    end

    // Store write: seed with 1 on a new transaction, else the new minimum
    assign we    = init || ctrl.gen;
    assign waddr = init ? '0 : count_reg[ADDR_W-1:0];
    assign wdata = init ? VALUE_W'(1) : cmin[VALUE_W-1:0];

    // Store read address select
    assign last_idx = n_reg - INDEX_W'(1);
    always_comb
    begin
        unique case (ctrl.rd_src)
            RD_P2:   raddr = p2_reg;
            RD_P3:   raddr = p3_reg;
            RD_P5:   raddr = p5_reg;
            RD_LAST: raddr = last_idx[ADDR_W-1:0];
            default: raddr = p2_reg;
        endcase
    end

    nsng_ram #(
        .WIDTH  (VALUE_W),
        .DEPTH  (MAX_INDEX),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_value)
    );

    // Pointers and produced count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            p2_reg    <= '0;
            p3_reg    <= '0;
            p5_reg    <= '0;
        end
        else if (init)
        begin
            count_reg <= INDEX_W'(1);
            p2_reg    <= '0;
            p3_reg    <= '0;
            p5_reg    <= '0;
        end
        else if (ctrl.gen)
        begin
            count_reg <= count_reg + INDEX_W'(1);
            if (c2 == cmin) p2_reg <= p2_reg + ADDR_W'(1);
            if (c3 == cmin) p3_reg <= p3_reg + ADDR_W'(1);
            if (c5 == cmin) p5_reg <= p5_reg + ADDR_W'(1);
        end
    end

    // Payload: requested index and cached operands
    always_ff @(posedge clk)
    begin
        if (init)
        begin
            n_reg <= index;
        end
        case (ctrl.ld)
            LD_V2:   v2_reg <= rd_value;
            LD_V3:   v3_reg <= rd_value;
            LD_V5:   v5_reg <= rd_value;
            default: ;
        endcase
    end

    // A new value is only produced below the requested index and store size
    a_gen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.gen |-> (count_reg < n_reg) && (count_reg < INDEX_W'(MAX_INDEX)))
        else $error("generate step past requested index");

    // Every pointer refers to an entry already written
    a_ptr_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.gen |-> (INDEX_W'(p2_reg) < count_reg) && (INDEX_W'(p3_reg) < count_reg)
                     && (INDEX_W'(p5_reg) < count_reg))
        else $error("pointer beyond produced entries");

    // Each generate step advances at least one pointer
    a_ptr_moves: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.gen |=> (p2_reg != $past(p2_reg)) || (p3_reg != $past(p3_reg))
                     || (p5_reg != $past(p5_reg)))
        else $error("no pointer advanced");

endmodule

// ===== hdl/nth_smooth_number_generator_core.sv =====
// From acceptance, a valid index n runs CHECK, the build loop until n values are
// stored, FIN and EMIT to the done strobe; index 0 or above MAX_INDEX runs CHECK and
// ERR. Each value takes LOOP, RD3, RD5, LD5 and GEN, set by the single read port of
// the store (three reads). Start is taken only when idle; busy drops as done shows.
// Reset (rst_n, async, active low) returns the sequencer to idle; done is a
// one-cycle strobe that the receiver cannot stall.
// Top level: sequencer, datapath and result registers.
// Depends on nsng_pkg, nsng_sequencer, nsng_datapath.
`timescale 1ns / 1ps

module nth_smooth_number_generator_core #(
    parameter int MAX_INDEX = nsng_pkg::NSNG_MAX_INDEX
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [nsng_pkg::INDEX_W-1:0] index,
    output logic                         busy,
    output logic                         done,
    output logic [nsng_pkg::VALUE_W-1:0] value,
    output logic                         out_of_range
);
    import nsng_pkg::*;

    ctrl_t              ctrl;
    status_t            stat;
    logic [VALUE_W-1:0] rd_value;

    logic               done_reg;
    logic               done_next;
    logic               oor_reg;
    logic               oor_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    nsng_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    nsng_datapath #(
        .MAX_INDEX (MAX_INDEX)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .index    (index),
        .ctrl     (ctrl),
        .stat     (stat),
        .rd_value (rd_value)
    );

    // Result register
    assign done_next  = ctrl.emit_val || ctrl.emit_err;
    assign oor_next   = ctrl.emit_err;
    assign value_next = ctrl.emit_val ? rd_value : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            oor_reg   <= oor_next;
            value_reg <= value_next;
        end
    end

    assign done         = done_reg;
    assign value        = value_reg;
    assign out_of_range = oor_reg;

    // Block is idle again whenever a result is shown
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // An error result carries value zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |-> (value == '0))
        else $error("nonzero value on error");

    // An accepted transaction makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy && !done)
        else $error("accepted transaction did not start");

endmodule

// ===== test/nth_smooth_number_generator_core_tb.sv =====
// Testbench for nth_smooth_number_generator_core: drives indexes, predicts the
// n-th 2-3-5 smooth number per transaction and checks each done strobe.
// Depends on nsng_pkg and nth_smooth_number_generator_core.
`timescale 1ns / 1ps

module nth_smooth_number_generator_core_tb;

    localparam int MAX_IDX       = nsng_pkg::NSNG_MAX_INDEX;
    localparam int IDX_W         = nsng_pkg::INDEX_W;
    localparam int VAL_W         = nsng_pkg::VALUE_W;
    localparam int SEQ_AW        = (MAX_IDX > 1) ? $clog2(MAX_IDX) : 1;
    localparam int RANDOM_ITEMS  = 580;
    // Watchdog limit, well above the run time of the slowest valid request (MAX_IDX)
    localparam int STALL_LIMIT   = 25 * MAX_IDX;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             out_of_range;
    } smooth_result_t;

    // Scoreboard: rebuilds the smooth sequence per request with three pointers
    class smooth_scoreboard;
        logic [31:0]    seq_store [MAX_IDX];
        logic [IDX_W-1:0] ptr_two;
        logic [IDX_W-1:0] ptr_three;
        logic [IDX_W-1:0] ptr_five;
        logic [IDX_W-1:0] built_count;
        smooth_result_t expected_results [$];
        int unsigned    failures;

        function new();
            ptr_two     = '0;
            ptr_three   = '0;
            ptr_five    = '0;
            built_count = '0;
            failures    = 0;
        endfunction

        // Note an accepted transaction and queue its expected result
        function void note_index(logic [IDX_W-1:0] idx);
            smooth_result_t r;
            longint unsigned c2;
            longint unsigned c3;
            longint unsigned c5;
            longint unsigned nxt;
            logic [IDX_W-1:0] last_pos;
            if (idx == 0 || idx > MAX_IDX)
            begin
                r.value        = '0;
                r.out_of_range = 1'b1;
            end
            else
            begin
                seq_store[0] = 32'd1;
                ptr_two      = '0;
                ptr_three    = '0;
                ptr_five     = '0;
                built_count  = IDX_W'(1);
                while (built_count < idx)
                begin
                    c2  = longint'(seq_store[ptr_two[SEQ_AW-1:0]]) * 2;
                    c3  = longint'(seq_store[ptr_three[SEQ_AW-1:0]]) * 3;
                    c5  = longint'(seq_store[ptr_five[SEQ_AW-1:0]]) * 5;
                    nxt = (c2 < c3) ? c2 : c3;
                    nxt = (nxt < c5) ? nxt : c5;
                    seq_store[built_count[SEQ_AW-1:0]] = nxt[31:0];
                    built_count = built_count + IDX_W'(1);
                    // advance every pointer that hit the minimum: no duplicates
                    if (c2 == nxt) ptr_two = ptr_two + IDX_W'(1);
                    if (c3 == nxt) ptr_three = ptr_three + IDX_W'(1);
                    if (c5 == nxt) ptr_five = ptr_five + IDX_W'(1);
                end
                last_pos       = idx - IDX_W'(1);
                r.value        = seq_store[last_pos[SEQ_AW-1:0]][VAL_W-1:0];
                r.out_of_range = 1'b0;
            end
            expected_results.push_back(r);
        endfunction

        // Compare one strobed result with the oldest expectation
        function void check_result(logic [VAL_W-1:0] value, logic out_of_range);
            smooth_result_t r;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: value=%0d out_of_range=%0b", value, out_of_range);
                failures++;
                return;
            end
            r = expected_results.pop_front();
            if (value !== r.value)
            begin
                $error("value: expected %0d, actual %0d", r.value, value);
                failures++;
            end
            if (out_of_range !== r.out_of_range)
            begin
                $error("out_of_range: expected %0b, actual %0b", r.out_of_range, out_of_range);
                failures++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [IDX_W-1:0] index = '0;
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] value;
    logic             out_of_range;

    smooth_scoreboard sb = new();
    int unsigned      stall_cycles = 0;

    nth_smooth_number_generator_core #(
        .MAX_INDEX(MAX_IDX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .index(index),
        .busy(busy),
        .done(done),
        .value(value),
        .out_of_range(out_of_range)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result monitor: done is a one-cycle strobe
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(value, out_of_range);
    end

    // Watchdog: cycles with neither an accepted request nor a result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Send one transaction; start stays high into the next one unless idling
    task automatic send_index(input logic [IDX_W-1:0] idx, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_index(idx);
    endtask

    // Mostly short requests, some out of range, a few near the top
    function automatic logic [IDX_W-1:0] draw_index();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 68)
            return IDX_W'($urandom_range(64, 1));
        else if (pick < 83)
            return IDX_W'($urandom_range(300, 65));
        else if (pick < 88)
            return '0;
        else if (pick < 95)
            return IDX_W'($urandom_range(2047, MAX_IDX + 1));
        else
            return IDX_W'($urandom_range(MAX_IDX, MAX_IDX - 124));
    endfunction

    initial
    begin
        int idle_pct;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first values, first duplicate (6), range edges
        send_index(11'd1, 38);
        send_index(11'd2, 38);
        send_index(11'd3, 38);
        send_index(11'd4, 38);
        send_index(11'd5, 38);
        send_index(11'd6, 38);
        send_index(11'd7, 38);
        send_index(11'd10, 38);
        send_index(11'd11, 38);
        send_index(11'd0, 38);
        send_index(11'd1, 0);
        send_index(IDX_W'(MAX_IDX + 1), 38);
        send_index(11'd2047, 0);
        send_index(IDX_W'(MAX_IDX), 38);
        send_index(IDX_W'(MAX_IDX - 1), 0);
        send_index(11'd1690, 38);
        send_index(11'd512, 38);
        send_index(11'd100, 0);
        send_index(11'd0, 0);
        send_index(11'd1, 0);

        // Random: three idling phases
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_pct = (i < RANDOM_ITEMS / 3) ? 38 : (i < 2 * RANDOM_ITEMS / 3) ? 72 : 0;
            send_index(draw_index(), idle_pct);
        end
        start <= 1'b0;

        // Drain, then watch for stray strobes
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.pending() != 0)
            $error("%0d expected results never arrived", sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
